>>> hdl/far_pkg.sv
// ----------------------------------------------------------------------------
// far_pkg
// Widths and shared types for the fraction add and reduce block.
// ----------------------------------------------------------------------------
`default_nettype none

package far_pkg;

  localparam int FIELD_WIDTH = 16;

  localparam int NUM_W     = FIELD_WIDTH;
  localparam int DEN_W     = FIELD_WIDTH - 1;
  localparam int RES_NUM_W = 2 * FIELD_WIDTH;
  localparam int RES_DEN_W = 2 * FIELD_WIDTH - 2;

  // magnitude of the unreduced numerator, and the divider's trial width
  localparam int MAG_W = RES_NUM_W - 1;
  localparam int ALU_W = MAG_W + 1;
  localparam int CNT_W = $clog2(MAG_W);

  typedef struct packed {
    logic             ge;    // a >= b, unsigned
    logic [ALU_W-1:0] diff;  // a - b
  } alu_res_t;

endpackage

`default_nettype wire

>>> hdl/far_mul.sv
// ----------------------------------------------------------------------------
// far_mul
// Signed multiplier with a registered product, shared for all three products.
// ----------------------------------------------------------------------------
`default_nettype none

module far_mul
  import far_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic signed [NUM_W-1:0]     ma,
  input  wire logic signed [NUM_W-1:0]     mb,
  output logic signed      [RES_NUM_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

endmodule

`default_nettype wire

>>> hdl/far_alu.sv
// ----------------------------------------------------------------------------
// far_alu
// Shared subtract and compare unit for the GCD loop and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module far_alu
  import far_pkg::*;
(
  input  wire logic [ALU_W-1:0] a,
  input  wire logic [ALU_W-1:0] b,
  output alu_res_t              res
);

  logic [ALU_W:0] wide;

  always_comb begin
    wide     = {1'b0, a} - {1'b0, b};
    res.diff = wide[ALU_W-1:0];
    res.ge   = ~wide[ALU_W];   // no borrow
  end

endmodule

`default_nettype wire

>>> hdl/fraction_add_reduce.sv
// ----------------------------------------------------------------------------
// fraction_add_reduce
// Adds two fractions (or takes the first alone) and reduces to lowest terms.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                Payload
//  -------  -----------------------  ------------------------------------------
//  item     item_valid / item_stall  cmd, a_num, a_den, b_num, b_den
//  res      res_valid  / res_stall   res_num, res_den
//
//  One item at a time: item_stall is high from acceptance until the result
//  beat has been loaded into the output register.
//  Steps per item: the multiply states S_MUL0 to S_MUL3 (add only), a sign
//  step, the binary GCD loop (one shift or subtract per step, plus a step to
//  leave), then two restoring divisions of 31 quotient bits each and a load
//  step. Zero over zero skips the divisions.
//  The GCD loop and the divider share the subtract unit in far_alu.
//  rst is synchronous and clears the sequencer and res_valid.
//  A stalled result holds in the output register; the sequencer waits in its
//  final state until the register is free.
//
`default_nettype none

module fraction_add_reduce
  import far_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,

  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic                        cmd,
  input  wire logic signed [NUM_W-1:0]     a_num,
  input  wire logic        [DEN_W-1:0]     a_den,
  input  wire logic signed [NUM_W-1:0]     b_num,
  input  wire logic        [DEN_W-1:0]     b_den,

  output logic                             res_valid,
  input  wire logic                        res_stall,
  output logic signed      [RES_NUM_W-1:0] res_num,
  output logic             [RES_DEN_W-1:0] res_den
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_ABS, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_t;

  state_t state;

  // operands of an add
  logic signed [NUM_W-1:0]     an;
  logic        [DEN_W-1:0]     ad;
  logic signed [NUM_W-1:0]     bn;
  logic        [DEN_W-1:0]     bd;

  // unreduced result
  logic signed [RES_NUM_W-1:0] acc;
  logic        [RES_DEN_W-1:0] den;
  logic                        neg;
  logic        [MAG_W-1:0]     mag;

  // GCD loop
  logic        [MAG_W-1:0]     gx;
  logic        [MAG_W-1:0]     gy;
  logic        [CNT_W-1:0]     k;
  logic        [MAG_W-1:0]     g;

  // divider
  logic        [MAG_W-1:0]     rem;
  logic        [MAG_W-1:0]     q;
  logic        [CNT_W-1:0]     cnt;
  logic        [MAG_W-1:0]     qn;
  logic        [RES_DEN_W-1:0] qd;

  logic signed [NUM_W-1:0]     ma;
  logic signed [NUM_W-1:0]     mb;
  logic signed [RES_NUM_W-1:0] prod;
  logic        [ALU_W-1:0]     alu_a;
  logic        [ALU_W-1:0]     alu_b;
  alu_res_t                    alu;

  logic        [RES_NUM_W-1:0] magv;
  logic        [MAG_W-1:0]     gsrc;
  logic        [MAG_W-1:0]     gv;
  logic        [ALU_W-1:0]     trial;
  logic        [MAG_W-1:0]     q_step;
  logic        [MAG_W-1:0]     rem_step;
  logic                        div_last;
  logic        [RES_NUM_W-1:0] qn_ext;

  assign item_stall = (state != S_IDLE);

  far_mul u_mul (
    .clk  (clk),
    .ma   (ma),
    .mb   (mb),
    .prod (prod)
  );

  far_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  // Steer the multiplier: an*bd, then ad*bn, then ad*bd.
  always_comb begin
    case (state)
      S_MUL1: begin
        ma = signed'({1'b0, ad});
        mb = bn;
      end
      S_MUL2: begin
        ma = signed'({1'b0, ad});
        mb = signed'({1'b0, bd});
      end
      default: begin
        ma = an;
        mb = signed'({1'b0, bd});
      end
    endcase
  end

  // Steer the subtract unit: GCD compare, or one divider trial.
  always_comb begin
    trial = {rem, q[MAG_W-1]};
    case (state)
      S_GCD: begin
        alu_a = {1'b0, gx};
        alu_b = {1'b0, gy};
      end
      S_DIVN, S_DIVD: begin
        alu_a = trial;
        alu_b = {1'b0, g};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    magv     = acc[RES_NUM_W-1] ? RES_NUM_W'(-acc) : RES_NUM_W'(acc);
    gsrc     = (gx == '0) ? gy : gx;
    gv       = gsrc << k;
    q_step   = {q[MAG_W-2:0], alu.ge};
    rem_step = alu.ge ? alu.diff[MAG_W-1:0] : trial[MAG_W-1:0];
    div_last = (cnt == CNT_W'(MAG_W - 1));
    qn_ext   = {1'b0, qn};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // drop the result once taken; S_DONE reloads the register itself
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            an <= a_num;
            ad <= a_den;
            bn <= b_num;
            bd <= b_den;
            if (cmd) begin
              state <= S_MUL0;
            end else begin
              // reduce only: take the first fraction as it stands
              acc   <= RES_NUM_W'(a_num);
              den   <= RES_DEN_W'(a_den);
              state <= S_ABS;
            end
          end
        end

        S_MUL0: begin
          state <= S_MUL1;
        end

        S_MUL1: begin
          acc   <= prod;
          state <= S_MUL2;
        end

        S_MUL2: begin
          acc   <= acc + prod;
          state <= S_MUL3;
        end

        S_MUL3: begin
          den   <= prod[RES_DEN_W-1:0];
          state <= S_ABS;
        end

        S_ABS: begin
          neg   <= acc[RES_NUM_W-1];
          mag   <= magv[MAG_W-1:0];
          gx    <= magv[MAG_W-1:0];
          gy    <= {1'b0, den};
          k     <= '0;
          state <= S_GCD;
        end

        S_GCD: begin
          if (gx == '0 || gy == '0) begin
            if (gv == '0) begin
              // zero over zero: pass out unreduced
              qn    <= mag;
              qd    <= den;
              state <= S_DONE;
            end else begin
              g     <= gv;
              q     <= mag;
              rem   <= '0;
              cnt   <= '0;
              state <= S_DIVN;
            end
          end else if (!gx[0] && !gy[0]) begin
            // common factor of two: count it
            gx <= gx >> 1;
            gy <= gy >> 1;
            k  <= k + 1'b1;
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (alu.ge) begin
            gx <= alu.diff[MAG_W-1:0];
          end else begin
            gy <= MAG_W'(-alu.diff);
          end
        end

        S_DIVN: begin
          if (div_last) begin
            // numerator quotient done: start on the denominator
            qn    <= q_step;
            q     <= {1'b0, den};
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIVD;
          end else begin
            rem <= rem_step;
            q   <= q_step;
            cnt <= cnt + 1'b1;
          end
        end

        S_DIVD: begin
          rem <= rem_step;
          q   <= q_step;
          cnt <= cnt + 1'b1;
          if (div_last) begin
            qd    <= q_step[RES_DEN_W-1:0];
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!res_valid || !res_stall) begin
            res_num   <= neg ? signed'(-qn_ext) : signed'(qn_ext);
            res_den   <= qd;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The divider only ever runs against a nonzero GCD.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVN || state == S_DIVD) |-> (g != '0))
    else $error("divider running with a zero GCD");

  // Division of the denominator by the GCD is exact.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVD && div_last) |=> (rem == '0))
    else $error("denominator not divisible by the GCD");

  // A finished GCD loop leaves for the divider or the result.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_GCD && (gx == '0 || gy == '0)) |=> (state == S_DIVN || state == S_DONE))
    else $error("GCD loop did not finish");

  // No new item is taken while a result is still being worked out.
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> item_stall)
    else $error("item accepted while busy");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fraction_add_reduce: a directed table of corner
// beats, then randomised reduce and add beats, each checked against a typed-in
// answer or a rational-arithmetic predictor, with random idling and back-pressure.
// ----------------------------------------------------------------------------

module tb_top;
  import far_pkg::*;

  // --------------------------------------------------------------------------
  // Operation codes, beat layouts and run shape
  // --------------------------------------------------------------------------
  typedef enum logic {
    CMD_REDUCE = 1'b0,  // reduce the first fraction alone
    CMD_ADD    = 1'b1   // add both fractions, then reduce the sum
  } frac_cmd_t;

  typedef struct packed {
    frac_cmd_t               cmd;
    logic signed [NUM_W-1:0] a_num;
    logic [DEN_W-1:0]        a_den;
    logic signed [NUM_W-1:0] b_num;
    logic [DEN_W-1:0]        b_den;
  } frac_item_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] num;
    logic [RES_DEN_W-1:0]        den;
  } frac_res_t;

  // one directed row: the beat, and a typed-in answer where it is obvious
  typedef struct packed {
    frac_item_t item;
    bit         typed;
    frac_res_t  want;
  } frac_row_t;

  localparam int N_ROWS       = 23;
  localparam int RANDOM_BEATS = 1530;
  localparam int HOLD_AT      = 400;     // sender beat count that opens the hold-off
  localparam int HOLD_CYCLES  = 300;     // receiver hold-off length
  localparam int PAUSE_AT     = 880;     // random beat before which the sender drains
  localparam int CALM_FROM    = 1100;    // random beats with no idling on either side
  localparam int CALM_TO      = 1250;
  localparam int DRAIN_CYCLES = 250;     // settling wait after the last answer
  localparam int CYCLE_LIMIT  = 2000000;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        item_valid = 1'b0;
  logic                        item_stall;
  logic                        cmd        = 1'b0;
  logic signed [NUM_W-1:0]     a_num      = '0;
  logic [DEN_W-1:0]            a_den      = '0;
  logic signed [NUM_W-1:0]     b_num      = '0;
  logic [DEN_W-1:0]            b_den      = '0;

  logic                        res_valid;
  logic                        res_stall  = 1'b0;
  logic signed [RES_NUM_W-1:0] res_num;
  logic [RES_DEN_W-1:0]        res_den;

  always #6 clk = ~clk;

  fraction_add_reduce i_dut (.*);

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  frac_res_t expected_fracs [$];   // answers owed by the block, oldest first

  int n_errors   = 0;
  int n_sent     = 0;
  int n_reduce   = 0;
  int n_add      = 0;
  int n_results  = 0;
  int n_zero_den = 0;

  logic hold_off = 1'b0;  // long receiver hold-off, driven by its own process
  logic calm     = 1'b0;  // both sides run flat out while this is high

  // --------------------------------------------------------------------------
  // Directed table. Rows with typed = 1 carry an answer read straight off the
  // arithmetic; the rest are left to the predictor.
  // --------------------------------------------------------------------------
  frac_row_t corner_rows [N_ROWS] = '{
    // plain reduction, with junk in the second fraction where it is ignored
    '{'{CMD_REDUCE, 16'sd6,      15'd4,     16'sd0,      15'd1},     1'b1,
      '{32'sd3, 30'd2}},
    '{'{CMD_REDUCE, 16'sd12,     15'd18,   -16'sd1,      15'd32767}, 1'b1,
      '{32'sd2, 30'd3}},
    // zero numerator collapses to 0/1
    '{'{CMD_REDUCE, 16'sd0,      15'd5,     16'sd9,      15'd3},     1'b1,
      '{32'sd0, 30'd1}},
    // field extremes
    '{'{CMD_REDUCE, 16'sd32767,  15'd32767, 16'sd0,      15'd1},     1'b1,
      '{32'sd1, 30'd1}},
    '{'{CMD_REDUCE, 16'sh8000,   15'd1,     16'sd0,      15'd1},     1'b1,
      '{-32'sd32768, 30'd1}},
    '{'{CMD_REDUCE, 16'sh8000,   15'd32767, 16'sh8000,   15'd0},     1'b1,
      '{-32'sd32768, 30'd32767}},
    '{'{CMD_REDUCE, -16'sd1,     15'd1,     16'sd32767,  15'd32767}, 1'b1,
      '{-32'sd1, 30'd1}},
    // zero denominator: sign of the numerator over zero, 0/0 left as is
    '{'{CMD_REDUCE, 16'sd5,      15'd0,     16'sd0,      15'd1},     1'b1,
      '{32'sd1, 30'd0}},
    '{'{CMD_REDUCE, -16'sd7,     15'd0,     16'sd0,      15'd1},     1'b1,
      '{-32'sd1, 30'd0}},
    '{'{CMD_REDUCE, 16'sd0,      15'd0,     16'sd0,      15'd0},     1'b1,
      '{32'sd0, 30'd0}},
    // addition
    '{'{CMD_ADD,    16'sd1,      15'd2,     16'sd1,      15'd3},     1'b1,
      '{32'sd5, 30'd6}},
    '{'{CMD_ADD,    16'sd1,      15'd2,    -16'sd1,      15'd2},     1'b1,
      '{32'sd0, 30'd1}},
    '{'{CMD_ADD,    16'sd0,      15'd3,     16'sd0,      15'd7},     1'b1,
      '{32'sd0, 30'd1}},
    '{'{CMD_ADD,    16'sh8000,   15'd1,     16'sh8000,   15'd1},     1'b1,
      '{-32'sd65536, 30'd1}},
    '{'{CMD_ADD,    16'sd32767,  15'd1,     16'sd32767,  15'd1},     1'b1,
      '{32'sd65534, 30'd1}},
    '{'{CMD_ADD,    16'sd32767,  15'd32767, 16'sd32767,  15'd32767}, 1'b1,
      '{32'sd2, 30'd1}},
    '{'{CMD_ADD,    16'sh8000,   15'd32767, 16'sh8000,   15'd32767}, 1'b0, '0},
    '{'{CMD_ADD,    16'sd32767,  15'd32767, 16'sh8000,   15'd1},     1'b0, '0},
    '{'{CMD_ADD,    16'sd1,      15'd32767, 16'sd1,      15'd32766}, 1'b0, '0},
    '{'{CMD_ADD,    16'sh5555,   15'h2aaa,  16'shaaaa,   15'h5555},  1'b0, '0},
    // zero denominators in the sum
    '{'{CMD_ADD,    16'sd3,      15'd0,     16'sd1,      15'd2},     1'b1,
      '{32'sd1, 30'd0}},
    '{'{CMD_ADD,   -16'sd1,      15'd0,     16'sd0,      15'd5},     1'b1,
      '{-32'sd1, 30'd0}},
    '{'{CMD_ADD,    16'sd0,      15'd0,     16'sd0,      15'd0},     1'b1,
      '{32'sd0, 30'd0}}
  };

  // --------------------------------------------------------------------------
  // Predictor: cross-multiply when adding, then divide both terms by the GCD
  // of their magnitudes. A zero GCD (0/0) passes through unreduced.
  // --------------------------------------------------------------------------
  function automatic frac_res_t sum_in_lowest_terms(input frac_item_t it);
    longint          an, ad, bn, bd, num, den;
    longint unsigned mag, uden, x, y, t, qn, qd;
    bit              neg;
    frac_res_t       r;
    an = longint'(it.a_num);
    ad = longint'(it.a_den);
    bn = longint'(it.b_num);
    bd = longint'(it.b_den);
    if (it.cmd == CMD_ADD) begin
      num = an * bd + ad * bn;
      den = ad * bd;
    end else begin
      num = an;
      den = ad;
    end
    neg  = num < 0;
    mag  = neg ? -num : num;
    uden = den;
    // Euclid on the magnitudes
    x = mag;
    y = uden;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x == 0) begin
      qn = mag;
      qd = uden;
    end else begin
      qn = mag / x;
      qd = uden / x;
    end
    r.num = RES_NUM_W'(neg ? -qn : qn);
    r.den = RES_DEN_W'(qd);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random field values: mostly uniform, with a share of small values, zeros
  // and the two ends of each range
  // --------------------------------------------------------------------------
  function automatic logic signed [NUM_W-1:0] draw_num();
    logic signed [NUM_W-1:0] v;
    case ($urandom_range(0, 15))
      0, 1:    v = NUM_W'($urandom_range(0, 24) - 12);
      2:       v = {1'b1, {(NUM_W-1){1'b0}}};
      3:       v = {1'b0, {(NUM_W-1){1'b1}}};
      4:       v = '0;
      default: v = NUM_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [DEN_W-1:0] draw_den();
    logic [DEN_W-1:0] v;
    case ($urandom_range(0, 31))
      0:          v = '0;
      1, 2, 3, 4: v = DEN_W'($urandom_range(1, 16));
      5:          v = '1;
      default:    v = DEN_W'($urandom_range(1, (1 << DEN_W) - 1));
    endcase
    return v;
  endfunction

  // Idle length for either side: half of the time none, mostly short,
  // now and then long.
  function automatic int unsigned idle_len();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6, 7: return 0;
      15:                     return $urandom_range(20, 60);
      default:                return $urandom_range(1, 3);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Report one mismatch on one line and count it
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Sender: hold the beat until it is taken, then file its answer. Returns at
  // the accepting edge with nothing yet scheduled in that step.
  // --------------------------------------------------------------------------
  task automatic offer_beat(input frac_item_t it, input bit typed,
                            input frac_res_t typed_res);
    item_valid <= 1'b1;
    cmd        <= it.cmd;
    a_num      <= it.a_num;
    a_den      <= it.a_den;
    b_num      <= it.b_num;
    b_den      <= it.b_den;
    do @(posedge clk); while (item_stall);
    expected_fracs.push_back(typed ? typed_res : sum_in_lowest_terms(it));
    n_sent++;
    if (it.cmd == CMD_ADD) n_add++;
    else n_reduce++;
  endtask

  // Drop valid for a random gap; a zero gap keeps valid up for the next beat.
  task automatic sender_gap();
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: check every accepted beat against the oldest expectation and
  // pick the stall for the next cycle. Signals are sampled at the edge, so
  // they hold the values of the cycle just ended.
  // --------------------------------------------------------------------------
  int unsigned stall_run = 0;
  int unsigned free_run  = 0;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_fracs.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d with nothing outstanding",
                                  res_num, res_den));
      end else begin
        frac_res_t want;
        want = expected_fracs.pop_front();
        n_results++;
        if (want.den == 0) n_zero_den++;
        if (res_num !== want.num)
          report_mismatch($sformatf("res_num %0d, expected %0d (result %0d)",
                                    res_num, want.num, n_results));
        if (res_den !== want.den)
          report_mismatch($sformatf("res_den %0d, expected %0d (result %0d)",
                                    res_den, want.den, n_results));
      end
    end

    // exactly one assignment to res_stall per edge
    if (hold_off) begin
      res_stall <= 1'b1;
    end else if (rst || calm) begin
      res_stall <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run--;
      res_stall <= 1'b1;
    end else if (free_run != 0) begin
      free_run--;
      res_stall <= 1'b0;
    end else begin
      stall_run = idle_len();
      free_run  = $urandom_range(0, 6);
      res_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off while the sender keeps offering: the output
  // register fills, the sequencer parks, and item_stall must hold the input.
  // --------------------------------------------------------------------------
  initial begin : hold_off_window
    while (n_sent < HOLD_AT) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up well beyond the slowest legal run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[%0t] run still busy after %0d cycles", $time, CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset once, walk the table, then the random beats
  // --------------------------------------------------------------------------
  initial begin : stimulus
    frac_item_t  it;
    int unsigned k;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    for (int r = 0; r < N_ROWS; r++) begin
      offer_beat(corner_rows[r].item, corner_rows[r].typed, corner_rows[r].want);
      sender_gap();
    end

    // random beats
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      // once, drain the block completely before going on
      if (i == PAUSE_AT) begin
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_fracs.size() != 0);
      end
      if (i == CALM_FROM) calm <= 1'b1;
      if (i == CALM_TO) calm <= 1'b0;

      it.cmd = frac_cmd_t'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
        // share a factor across all four terms so reduction has real work
        k        = $urandom_range(1, 90);
        it.a_num = NUM_W'(k * ($urandom_range(0, 600) - 300));
        it.a_den = DEN_W'(k * $urandom_range(1, 360));
        it.b_num = NUM_W'(k * ($urandom_range(0, 600) - 300));
        it.b_den = DEN_W'(k * $urandom_range(1, 360));
      end else begin
        it.a_num = draw_num();
        it.a_den = draw_den();
        it.b_num = draw_num();
        it.b_den = draw_den();
      end
      offer_beat(it, 1'b0, '0);
      sender_gap();
    end

    // wait out every answer, then a latency's worth for strays
    item_valid <= 1'b0;
    while (expected_fracs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d reduce and %0d add beats, with zero terms, extremes and stalls.",
             n_reduce, n_add);
    $display("Checked %0d results (%0d over a zero denominator), %0d mismatches.",
             n_results, n_zero_den, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/far_pkg.sv
hdl/far_mul.sv
hdl/far_alu.sv
hdl/fraction_add_reduce.sv
test/tb_top.sv
